### rtl/tftlb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tftlb_pkg
// Shared constants, codes and types of the tiled framebuffer TLB translator.
// ----------------------------------------------------------------------------
package tftlb_pkg;

    // TLB sizes in 64-bit words per bank
    localparam int TILED_TLB_ENTRIES  = 64;
    localparam int LINEAR_TLB_ENTRIES = 16;

    localparam int TILED_BANKS  = 3;
    localparam int LINEAR_BANKS = 2;

    localparam int TT_DEPTH  = TILED_BANKS * TILED_TLB_ENTRIES;
    localparam int LT_DEPTH  = LINEAR_BANKS * LINEAR_TLB_ENTRIES;
    localparam int TT_IDX_W  = (TILED_TLB_ENTRIES > 1) ? $clog2(TILED_TLB_ENTRIES) : 1;
    localparam int LT_IDX_W  = (LINEAR_TLB_ENTRIES > 1) ? $clog2(LINEAR_TLB_ENTRIES) : 1;
    localparam int TT_ADDR_W = $clog2(TT_DEPTH);
    localparam int LT_ADDR_W = $clog2(LT_DEPTH);

    localparam int PA_W = 43;

    // operation codes
    localparam logic [1:0] OP_WR_TILED  = 2'd0;
    localparam logic [1:0] OP_WR_LINEAR = 2'd1;
    localparam logic [1:0] OP_XLATE     = 2'd2;

    // buffer types served by the linear banks, and the highest tiled type
    localparam logic [2:0] BT_LINEAR0 = 3'd4;
    localparam logic [2:0] BT_LINEAR1 = 3'd5;
    localparam logic [2:0] BT_TILED_MAX = 3'd2;

    // pixel packing codes
    localparam logic [1:0] PIX_INDEX = 2'd0;
    localparam logic [1:0] PIX_RGB   = 2'd1;

    // tiled and linear descriptor valid bits
    localparam int TDESC_VALID = 15;
    localparam int LDESC_VALID = 31;

    typedef enum logic [1:0] {
        K_NONE   = 2'd0,
        K_TILED  = 2'd1,
        K_LINEAR = 2'd2
    } t_kind;

    // decoded lookup of one translate transaction
    typedef struct packed {
        t_kind                  kind;
        logic                   ok;      // coordinates map into the TLB
        logic [TT_ADDR_W-1:0]   tt_addr;
        logic [LT_ADDR_W-1:0]   lt_addr;
        logic [1:0]             sub;     // tile descriptor within the word
        logic                   half;    // odd linear page
        logic [15:0]            offset;  // byte offset inside tile or page
    } t_lookup;

endpackage

### rtl/tftlb_xlate_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tftlb_xlate_front
// Decodes a pixel into the TLB word address, descriptor select and byte
// offset for either tiled or linear buffers.
// ----------------------------------------------------------------------------
module tftlb_xlate_front (
    input  logic [2:0]              i_buf_type,
    input  logic [1:0]              i_depth_code,
    input  logic signed [17:0]      i_pixel_x,
    input  logic signed [15:0]      i_pixel_y,
    output tftlb_pkg::t_lookup      o_lookup
);
    import tftlb_pkg::*;

    logic        t_in_range;
    logic [10:0] xs;
    logic [10:0] ys;
    logic [10:0] x_shift;
    logic [8:0]  tile;
    logic [6:0]  t_word;
    logic [8:0]  x_mask;
    logic [8:0]  x_mod;
    logic [8:0]  x_off;
    logic        l_ok;
    logic [4:0]  l_page;
    logic [6:0]  l_word;

    always_comb begin
        xs = i_pixel_x[10:0];
        ys = i_pixel_y[10:0];
        t_in_range = !i_pixel_x[17] && (i_pixel_x[16:11] == 6'd0)
                   && !i_pixel_y[15] && (i_pixel_y[14:11] == 4'd0);

        // tile width is 512 / bytes-per-pixel pixels
        x_shift = xs >> (4'd9 - {2'b00, i_depth_code});
        tile    = {1'b0, ys[10:7], 4'b0000} + {4'b0000, x_shift[4:0]};
        t_word  = tile[8:2];
        x_mask  = 9'h1ff >> i_depth_code;
        x_mod   = xs[8:0] & x_mask;
        x_off   = x_mod << i_depth_code;

        l_page = i_pixel_x[16:12];
        l_word = {3'b000, l_page[4:1]};
        l_ok   = !i_pixel_x[17] && (l_word < 7'(LINEAR_TLB_ENTRIES));

        o_lookup.tt_addr = TT_ADDR_W'(i_buf_type[1:0]) * TT_ADDR_W'(TILED_TLB_ENTRIES)
                         + TT_ADDR_W'(t_word[TT_IDX_W-1:0]);
        o_lookup.lt_addr = LT_ADDR_W'(i_buf_type[0]) * LT_ADDR_W'(LINEAR_TLB_ENTRIES)
                         + LT_ADDR_W'(l_word[LT_IDX_W-1:0]);
        o_lookup.half    = l_page[0];

        if (i_buf_type <= BT_TILED_MAX) begin
            o_lookup.kind   = K_TILED;
            o_lookup.ok     = t_in_range && ({1'b0, t_word} < 8'(TILED_TLB_ENTRIES));
            o_lookup.sub    = tile[1:0];
            o_lookup.offset = {ys[6:0], x_off};
        end else if (i_buf_type == BT_LINEAR0 || i_buf_type == BT_LINEAR1) begin
            o_lookup.kind   = K_LINEAR;
            o_lookup.ok     = l_ok;
            o_lookup.sub    = 2'd0;
            o_lookup.offset = {4'd0, i_pixel_x[11:0]};
        end else begin
            o_lookup.kind   = K_NONE;
            o_lookup.ok     = 1'b0;
            o_lookup.sub    = 2'd0;
            o_lookup.offset = 16'd0;
        end
    end

endmodule

### rtl/tiled_framebuffer_tlb_translate.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tiled_framebuffer_tlb_translate
// Tiled and linear framebuffer TLB: writes TLB words and translates pixels
// to physical byte addresses with the packed bytes to store.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+-----------------------------
//  in      | input     | i_in_valid / o_in_ready   | op, bank, index, TLB word, pixel
//  out     | output    | o_out_valid / i_out_ready | hit, phys_addr, byte_count, data
//
//  Every transaction produces one result: the read stage registers the
//  synchronous TLB memory read, and descriptor select and packing feed
//  the output register. One transaction is accepted per cycle while the
//  output drains. Reset clears the valid bit of every TLB word, so
//  all tiles and pages read as unmapped; no clearing pass is needed.
//  A stalled output holds the read stage, which holds the input.
// ----------------------------------------------------------------------------
module tiled_framebuffer_tlb_translate (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic [1:0]              i_op,
    input  logic [1:0]              i_bank,
    input  logic [5:0]              i_entry_index,
    input  logic [63:0]             i_tlb_word,
    input  logic [2:0]              i_buf_type,
    input  logic [1:0]              i_depth_code,
    input  logic [1:0]              i_pix_type,
    input  logic signed [17:0]      i_pixel_x,
    input  logic signed [15:0]      i_pixel_y,
    input  logic [31:0]             i_pixel_color,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic                    o_hit,
    output logic [tftlb_pkg::PA_W-1:0] o_phys_addr,
    output logic [2:0]              o_byte_count,
    output logic [31:0]             o_write_data
);
    import tftlb_pkg::*;

    t_lookup                lookup;
    logic                   accept;
    logic                   a_go;
    logic                   b_go;
    logic                   wr_tt;
    logic                   wr_lt;
    logic [TT_ADDR_W-1:0]   wr_tt_addr;
    logic [LT_ADDR_W-1:0]   wr_lt_addr;
    logic [6:0]             wr_idx;

    // TLB memories and their valid bits
    logic [63:0]            tt_mem [TT_DEPTH];
    logic [63:0]            lt_mem [LT_DEPTH];
    logic [TT_DEPTH-1:0]    r_tt_vld;
    logic [LT_DEPTH-1:0]    r_lt_vld;

    // read stage
    logic                   r_a_valid;
    logic                   r_a_xlate;
    t_lookup                r_a_lookup;
    logic [1:0]             r_a_pix_type;
    logic [31:0]            r_a_color;
    logic [63:0]            r_tt_rdata;
    logic                   r_tt_rvld;
    logic [63:0]            r_lt_rdata;
    logic                   r_lt_rvld;

    // output register
    logic                   r_out_valid;
    logic                   r_hit;
    logic [PA_W-1:0]        r_pa;
    logic [2:0]             r_cnt;
    logic [31:0]            r_data;
    logic                   n_hit;
    logic [PA_W-1:0]        n_pa;
    logic [2:0]             n_cnt;
    logic [31:0]            n_data;
    logic [15:0]            tdesc;
    logic [31:0]            ldesc;

    tftlb_xlate_front u_front (
        .i_buf_type   (i_buf_type),
        .i_depth_code (i_depth_code),
        .i_pixel_x    (i_pixel_x),
        .i_pixel_y    (i_pixel_y),
        .o_lookup     (lookup)
    );

    assign b_go       = r_a_valid && (!r_out_valid || i_out_ready);
    assign a_go       = !r_a_valid || b_go;
    assign o_in_ready = a_go;
    assign accept     = i_in_valid && a_go;

    // write decode
    always_comb begin
        wr_idx     = {1'b0, i_entry_index};
        wr_tt      = accept && (i_op == OP_WR_TILED) && (i_bank != 2'd3)
                   && (wr_idx < 7'(TILED_TLB_ENTRIES));
        wr_lt      = accept && (i_op == OP_WR_LINEAR) && !i_bank[1]
                   && (wr_idx < 7'(LINEAR_TLB_ENTRIES));
        wr_tt_addr = TT_ADDR_W'(i_bank) * TT_ADDR_W'(TILED_TLB_ENTRIES)
                   + TT_ADDR_W'(wr_idx[TT_IDX_W-1:0]);
        wr_lt_addr = LT_ADDR_W'(i_bank[0]) * LT_ADDR_W'(LINEAR_TLB_ENTRIES)
                   + LT_ADDR_W'(wr_idx[LT_IDX_W-1:0]);
    end

    // memory ports: write on an accepted write, read on accept
    always_ff @(posedge i_clk) begin
        if (wr_tt) begin
            tt_mem[wr_tt_addr] <= i_tlb_word;
        end
        if (wr_lt) begin
            lt_mem[wr_lt_addr] <= i_tlb_word;
        end
        if (accept) begin
            r_tt_rdata <= tt_mem[lookup.tt_addr];
            r_lt_rdata <= lt_mem[lookup.lt_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tt_vld <= '0;
            r_lt_vld <= '0;
        end else begin
            if (wr_tt) begin
                r_tt_vld[wr_tt_addr] <= 1'b1;
            end
            if (wr_lt) begin
                r_lt_vld[wr_lt_addr] <= 1'b1;
            end
        end
    end

    // read stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (a_go) begin
            r_a_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a_xlate    <= (i_op == OP_XLATE);
            r_a_lookup   <= lookup;
            r_a_pix_type <= i_pix_type;
            r_a_color    <= i_pixel_color;
            r_tt_rvld    <= r_tt_vld[lookup.tt_addr];
            r_lt_rvld    <= r_lt_vld[lookup.lt_addr];
        end
    end

    // descriptor select and byte packing
    always_comb begin
        case (r_a_lookup.sub)
            2'd0:    tdesc = r_tt_rdata[63:48];
            2'd1:    tdesc = r_tt_rdata[47:32];
            2'd2:    tdesc = r_tt_rdata[31:16];
            default: tdesc = r_tt_rdata[15:0];
        endcase
        ldesc = r_a_lookup.half ? r_lt_rdata[31:0] : r_lt_rdata[63:32];

        n_hit  = 1'b0;
        n_pa   = '0;
        n_cnt  = 3'd0;
        n_data = 32'd0;
        if (r_a_xlate && r_a_lookup.ok) begin
            case (r_a_lookup.kind)
                K_TILED: begin
                    n_hit = r_tt_rvld && tdesc[TDESC_VALID];
                    n_pa  = PA_W'({tdesc[14:0], r_a_lookup.offset});
                end
                K_LINEAR: begin
                    n_hit = r_lt_rvld && ldesc[LDESC_VALID];
                    n_pa  = {ldesc[30:0], r_a_lookup.offset[11:0]};
                end
                default: begin
                    n_hit = 1'b0;
                end
            endcase
        end
        if (!n_hit) begin
            n_pa = '0;
        end else begin
            case (r_a_pix_type)
                PIX_INDEX: begin
                    n_cnt  = 3'd1;
                    n_data = {r_a_color[7:0], 24'd0};
                end
                PIX_RGB: begin
                    n_cnt  = 3'd4;
                    n_data = {r_a_color[31:8], 8'd0};
                end
                default: begin
                    n_cnt  = 3'd4;
                    n_data = r_a_color;
                end
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (b_go) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_go) begin
            r_hit  <= n_hit;
            r_pa   <= n_pa;
            r_cnt  <= n_cnt;
            r_data <= n_data;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_hit        = r_hit;
    assign o_phys_addr  = r_pa;
    assign o_byte_count = r_cnt;
    assign o_write_data = r_data;

endmodule
